>>> sv/bca_pkg.sv
// bca_pkg: shared types and codes for the bitmap chunk allocator
// controller states, status codes, request kinds, register indexes and the free-bit search
// depends on nothing; imported by bitmap_chunk_allocator, bca_tb_pkg and the testbench
package bca_pkg;

   localparam int CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_READY   = 8'd1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FAIL   = 2'd1;
   localparam logic [1:0] STATUS_NOINIT = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_MUL,
      S_ADD,
      S_DIV,
      S_QMUL,
      S_FIX,
      S_FREE_RD,
      S_FREE_WR,
      S_PUT
   } state_type;

   // position of the lowest free chunk in a byte; chunk 0 of the byte sits in bit 7
   function automatic logic [2:0] first_free(input logic [7:0] map_byte);
      logic [2:0] pos;
      logic       found;
      pos   = 3'd0;
      found = 1'b0;
      for (int j = 0; j < 8; j++) begin
         if (!found && !map_byte[7-j]) begin
            pos   = 3'(j);
            found = 1'b1;
         end
      end
      return pos;
   endfunction

endpackage

>>> sv/bitmap_chunk_allocator.sv
// bitmap_chunk_allocator: fixed-size chunk allocator over a byte-wide used bitmap in block memory
// alloc scans the bitmap one byte per cycle; free finds the chunk by a reciprocal multiply
// depends on bca_pkg
//
// Serves one request at a time. After reset a clearing pass writes the bitmap to zero, one byte
// per cycle over all MAP_BYTES bytes ((CHUNK_COUNT+7)/8, 32 at the default size), during which
// no request is taken; configuration writes are taken at any time. An alloc reads the bitmap
// one byte per cycle through the single read port of the memory and stops at the first byte
// with a clear bit, then forms the address by a multiply and an add; a full pool fails once
// the last byte is checked. A free multiplies the offset by the reciprocal of the chunk size,
// checks the remainder, then reads and writes back one byte; an offset that is not aligned
// fails at the remainder check. A request with a bad address or with the pool not ready goes
// straight to the response. The next request is taken in the cycle after the response is
// loaded; a response held by the receiver stalls the next one only once it is ready to be loaded.
module bitmap_chunk_allocator #(
   parameter int CHUNK_COUNT = 256,
   parameter int CHUNK_BYTES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // [31:0] free_address
   input  logic [0:0]                       req_tuser,   // [0] req_type
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [39:0]                      rsp_tdata,   // [31:0] alloc_address, [39:32] chunk_index
   output logic [1:0]                       rsp_tuser,   // [1:0] status
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bca_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_data
);
   import bca_pkg::*;

   localparam int MAP_BYTES = (CHUNK_COUNT + 7) / 8;
   localparam int MAP_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int NW        = MAP_W + 3;
   localparam int TAIL_USED = CHUNK_COUNT - 8 * (MAP_BYTES - 1);

   localparam logic [MAP_W-1:0] LAST_BYTE  = MAP_W'(MAP_BYTES - 1);
   localparam logic [7:0]       TAIL_PAD   = 8'(8'hff >> TAIL_USED);
   localparam logic [31:0]      POOL_BYTES = 32'(CHUNK_COUNT * CHUNK_BYTES);
   localparam logic [31:0]      CB32       = 32'(CHUNK_BYTES);
   // floor((2^32-1)/CHUNK_BYTES); the quotient estimate is exact or one low
   localparam logic [31:0]      RECIP      = 32'(64'hffff_ffff / CHUNK_BYTES);

   // bitmap store
   logic [7:0]       map_mem [0:MAP_BYTES-1];
   logic [7:0]       mem_q_ff;
   logic             mem_we;
   logic [MAP_W-1:0] mem_wa;
   logic [7:0]       mem_wd;
   logic [MAP_W-1:0] mem_ra;

   state_type        state_ff, state_in;
   logic [MAP_W-1:0] clr_addr_ff, clr_addr_in;
   logic [MAP_W-1:0] rd_addr_ff, rd_addr_in;
   logic [MAP_W-1:0] chk_addr_ff, chk_addr_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [31:0]      off_ff, off_in;
   logic [63:0]      recip_ff, recip_in;
   logic [31:0]      prod_ff, prod_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [31:0]      res_addr_ff, res_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [39:0]      rsp_data_ff, rsp_data_in;
   logic [1:0]       rsp_user_ff, rsp_user_in;
   logic [31:0]      base_ff, base_in;
   logic             ready_ff, ready_in;

   logic [31:0]      offset;
   logic [7:0]       scan_byte;
   logic [2:0]       free_pos;
   logic [31:0]      fix_rem;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= map_mem[mem_ra];
   end

   // register writes
   always_comb begin
      base_in  = base_ff;
      ready_in = ready_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_in  = csr_data;
            CSR_POOL_READY:   ready_in = csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   assign offset    = req_tdata - base_ff;
   assign scan_byte = mem_q_ff | ((chk_addr_ff == LAST_BYTE) ? TAIL_PAD : 8'h00);
   assign free_pos  = first_free(scan_byte);
   assign fix_rem   = off_ff - prod_ff;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      rd_addr_in    = rd_addr_ff;
      chk_addr_in   = chk_addr_ff;
      chk_vld_in    = 1'b0;
      n_in          = n_ff;
      off_in        = off_ff;
      recip_in      = recip_ff;
      prod_in       = prod_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mem_we        = 1'b0;
      mem_wa        = chk_addr_ff;
      mem_wd        = 8'h00;
      mem_ra        = rd_addr_ff;
      req_tready    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_addr_ff;
            mem_wd = 8'h00;
            if (clr_addr_ff == LAST_BYTE) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               n_in        = '0;
               res_addr_in = '0;
               if (!ready_ff) begin
                  res_status_in = STATUS_NOINIT;
                  state_in      = S_PUT;
               end else if (req_tuser[0] == REQ_ALLOC) begin
                  rd_addr_in = '0;
                  state_in   = S_SCAN;
               end else if (req_tdata == 32'd0 || offset >= POOL_BYTES) begin
                  res_status_in = STATUS_FAIL;
                  state_in      = S_PUT;
               end else begin
                  off_in   = offset;
                  state_in = S_DIV;
               end
            end
         end

         // one read issued per cycle; the byte read last cycle is checked now
         S_SCAN: begin
            mem_ra      = rd_addr_ff;
            rd_addr_in  = (rd_addr_ff == LAST_BYTE) ? rd_addr_ff : rd_addr_ff + 1'b1;
            chk_addr_in = rd_addr_ff;
            chk_vld_in  = 1'b1;
            if (chk_vld_ff) begin
               if (scan_byte != 8'hff) begin
                  mem_we   = 1'b1;
                  mem_wa   = chk_addr_ff;
                  mem_wd   = mem_q_ff | (8'h80 >> free_pos);
                  n_in     = {chk_addr_ff, free_pos};
                  state_in = S_MUL;
               end else if (chk_addr_ff == LAST_BYTE) begin
                  res_status_in = STATUS_FAIL;
                  state_in      = S_PUT;
               end
            end
         end

         S_MUL: begin
            prod_in  = 32'(n_ff) * CB32;
            state_in = S_ADD;
         end

         S_ADD: begin
            res_addr_in   = base_ff + prod_ff;
            res_status_in = STATUS_OK;
            state_in      = S_PUT;
         end

         // offset times the reciprocal of the chunk size
         S_DIV: begin
            recip_in = {32'd0, off_ff} * {32'd0, RECIP};
            state_in = S_QMUL;
         end

         S_QMUL: begin
            n_in     = recip_ff[32 +: NW];
            prod_in  = 32'(recip_ff[32 +: NW]) * CB32;
            state_in = S_FIX;
         end

         // remainder is below twice the chunk size; one chunk left over means one low
         S_FIX: begin
            if (fix_rem == 32'd0) begin
               state_in = S_FREE_RD;
            end else if (fix_rem == CB32) begin
               n_in     = n_ff + 1'b1;
               state_in = S_FREE_RD;
            end else begin
               // offset not aligned to the chunk size
               n_in          = '0;
               res_status_in = STATUS_FAIL;
               state_in      = S_PUT;
            end
         end

         S_FREE_RD: begin
            mem_ra   = n_ff[NW-1:3];
            state_in = S_FREE_WR;
         end

         S_FREE_WR: begin
            mem_we        = 1'b1;
            mem_wa        = n_ff[NW-1:3];
            mem_wd        = mem_q_ff & ~(8'h80 >> n_ff[2:0]);
            res_status_in = STATUS_OK;
            state_in      = S_PUT;
         end

         S_PUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {8'(n_ff), res_addr_ff};
               rsp_user_in  = res_status_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rd_addr_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         ready_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_addr_ff   <= rd_addr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         ready_ff     <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff   <= chk_addr_in;
      n_ff          <= n_in;
      off_ff        <= off_in;
      recip_ff      <= recip_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> dv/bca_tb_pkg.sv
// bca_tb_pkg: response predictor and scoreboard for the bitmap chunk allocator testbench
// keeps its own copy of the used map and both registers; depends on bca_pkg
package bca_tb_pkg;
   import bca_pkg::*;

   localparam int POOL_CHUNKS = 256;
   localparam int CHUNK_SIZE  = 64;
   localparam int MAP_LEN     = (POOL_CHUNKS + 7) / 8;
   localparam logic [31:0] POOL_SPAN = 32'(POOL_CHUNKS * CHUNK_SIZE);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] address;
      logic [7:0]  index;
   } chunk_reply_type;

   class chunk_pool_scoreboard;
      logic [7:0]      used_map [MAP_LEN];
      logic [31:0]     base_address;
      logic            pool_ready;
      chunk_reply_type replies_due [$];
      int unsigned     mismatches;

      function new();
         foreach (used_map[i]) used_map[i] = 8'h00;
         base_address = '0;
         pool_ready   = 1'b0;
         mismatches   = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [31:0] data);
         case (index)
            CSR_BASE_ADDRESS: base_address = data;
            CSR_POOL_READY:   pool_ready   = data[0];
            default: ;
         endcase
      endfunction

      // lowest chunk of each map byte sits in its top bit
      function bit is_used(int chunk);
         return used_map[chunk >> 3][7 - (chunk & 7)];
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      function void note_request(logic kind, logic [31:0] free_address);
         chunk_reply_type reply;
         logic [31:0]     offset;
         int              chunk;
         reply.status  = STATUS_FAIL;
         reply.address = '0;
         reply.index   = '0;
         if (!pool_ready) begin
            reply.status = STATUS_NOINIT;
         end else if (kind == REQ_ALLOC) begin
            chunk = 0;
            while (chunk < POOL_CHUNKS && is_used(chunk)) chunk++;
            if (chunk < POOL_CHUNKS) begin
               used_map[chunk >> 3][7 - (chunk & 7)] = 1'b1;
               reply.status  = STATUS_OK;
               reply.address = base_address + 32'(chunk * CHUNK_SIZE);
               reply.index   = 8'(chunk);
            end
         end else begin
            // alignment is judged on the wrapped offset, not the absolute address
            offset = free_address - base_address;
            if (free_address != 32'd0 && offset < POOL_SPAN &&
                offset % 32'(CHUNK_SIZE) == 32'd0) begin
               chunk = int'(offset / 32'(CHUNK_SIZE));
               used_map[chunk >> 3][7 - (chunk & 7)] = 1'b0;
               reply.status = STATUS_OK;
               reply.index  = 8'(chunk);
            end
         end
         replies_due.push_back(reply);
      endfunction

      function void check_response(logic [1:0] status, logic [31:0] address, logic [7:0] index);
         chunk_reply_type due;
         if (replies_due.size() == 0) begin
            $display("%0t: response with no request outstanding: status %0d address %h index %0d",
                     $time, status, address, index);
            mismatches++;
            return;
         end
         due = replies_due.pop_front();
         if (status !== due.status) begin
            $display("%0t: status expected %0d actual %0d", $time, due.status, status);
            mismatches++;
         end
         if (address !== due.address) begin
            $display("%0t: alloc_address expected %h actual %h", $time, due.address, address);
            mismatches++;
         end
         if (index !== due.index) begin
            $display("%0t: chunk_index expected %0d actual %0d", $time, due.index, index);
            mismatches++;
         end
      endfunction
   endclass

endpackage

>>> dv/tb_bitmap_chunk_allocator.sv
// tb_bitmap_chunk_allocator: directed and random alloc/free traffic with response checking
// drives the request, response and register channels; depends on bca_pkg and bca_tb_pkg
module tb_bitmap_chunk_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import bca_pkg::*;
   import bca_tb_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_NEXT = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_TOP  = 8'hff;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [31:0]            req_tdata;
   logic [0:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [39:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_data;

   chunk_pool_scoreboard sb = new();
   bit                   idles_on;
   int                   rsp_stall_left = 0;
   int                   quiet_cycles = 0;

   bitmap_chunk_allocator #(
      .CHUNK_COUNT(POOL_CHUNKS),
      .CHUNK_BYTES(CHUNK_SIZE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure in random bursts
   always @(negedge clock) begin
      if (rsp_stall_left == 0 && idles_on && $urandom_range(0, 5) == 0)
         rsp_stall_left = $urandom_range(1, 10);
      if (rsp_stall_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata[31:0], rsp_tdata[39:32]);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(logic kind, logic [31:0] address);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = address;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(kind, address);
   endtask

   task automatic hold_requests(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_register(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] pick_free_address();
      int chunk;
      int k;
      chunk = $urandom_range(0, POOL_CHUNKS - 1);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            // aim at a chunk in use so the free has an effect
            for (k = 0; k < POOL_CHUNKS && !sb.is_used(chunk); k++)
               chunk = (chunk + 1) % POOL_CHUNKS;
            return sb.base_address + 32'(chunk * CHUNK_SIZE);
         end
         6: return sb.base_address + 32'(chunk * CHUNK_SIZE);
         7: return $urandom();
         8: return sb.base_address + 32'(chunk * CHUNK_SIZE) +
                   32'($urandom_range(1, CHUNK_SIZE - 1));
         default: return sb.base_address + POOL_SPAN + 32'(chunk * CHUNK_SIZE);
      endcase
   endfunction

   task automatic run_mix(int count, int alloc_pct);
      logic kind;
      for (int i = 0; i < count; i++) begin
         if (idles_on && $urandom_range(0, 3) == 0)
            hold_requests($urandom_range(1, 10));
         if (i == count / 2)
            wait_drained();
         kind = ($urandom_range(1, 100) <= alloc_pct) ? REQ_ALLOC : REQ_FREE;
         send_request(kind, kind == REQ_ALLOC ? 32'($urandom()) : pick_free_address());
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      idles_on       = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // pool not ready yet; unknown register indexes must be dropped
      write_csr(CSR_UNUSED_NEXT, 32'h0000_0001);
      write_csr(CSR_UNUSED_TOP, 32'hffff_ffff);
      send_request(REQ_ALLOC, 32'h0);
      send_request(REQ_FREE, 32'h40);
      send_request(REQ_FREE, 32'h0);
      wait_drained();

      write_csr(CSR_BASE_ADDRESS, 32'h0);
      write_csr(CSR_POOL_READY, 32'h1);
      send_request(REQ_ALLOC, 32'h0);                       // chunk 0 lands on address 0
      send_request(REQ_FREE, 32'h0);                        // zero address never frees
      send_request(REQ_ALLOC, 32'hffff_ffff);
      send_request(REQ_FREE, 32'h40);
      send_request(REQ_FREE, 32'h40);                       // already free
      send_request(REQ_FREE, 32'h41);
      send_request(REQ_FREE, POOL_SPAN);                    // one chunk past the end
      send_request(REQ_FREE, POOL_SPAN - 32'(CHUNK_SIZE));  // last chunk
      send_request(REQ_FREE, 32'hffff_ffff);
      send_request(REQ_ALLOC, 32'h0);
      send_request(REQ_ALLOC, 32'h0);
      wait_drained();

      // unaligned base: addresses wrap past the top
      write_csr(CSR_BASE_ADDRESS, 32'hffff_ffff);
      send_request(REQ_FREE, 32'h0000_003f);
      send_request(REQ_FREE, 32'hffff_ffff);
      send_request(REQ_FREE, 32'h0000_3ffe);
      send_request(REQ_ALLOC, 32'h0);
      wait_drained();

      write_csr(CSR_BASE_ADDRESS, 32'hffff_f000);
      send_request(REQ_FREE, 32'h0);
      send_request(REQ_FREE, 32'hffff_efc0);                // just below the pool
      wait_drained();

      // alloc heavy, runs the pool full
      run_mix(320, 95);
      wait_drained();
      write_csr(CSR_BASE_ADDRESS, $urandom());
      write_csr(CSR_POOL_READY, 32'($urandom()) | 32'h1);
      run_mix(200, 30);
      wait_drained();
      write_csr(CSR_POOL_READY, 32'($urandom()) & ~32'h1);
      run_mix(30, 50);
      wait_drained();
      write_csr(CSR_BASE_ADDRESS, $urandom());
      write_csr(CSR_POOL_READY, 32'h1);
      run_mix(100, 60);
      wait_drained();

      idles_on = 1'b0;
      write_csr(CSR_BASE_ADDRESS, 32'h0);
      run_mix(100, 45);
      wait_drained();
      repeat (40) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
